// ----- hdl/aflc_pkg.sv -----
package aflc_pkg;

    // Fixed-point layout of frame values
    localparam int FRAC_BITS   = 16;
    localparam int MAX_FRAMES  = 100000;
    localparam int PROD_FRAC   = 24;                      // Q15.16 * Q8.8
    localparam int PROD_SHIFT  = PROD_FRAC - FRAC_BITS;

    // Field and datapath widths
    localparam int RATE_W  = 16;
    localparam int FRAME_W = 33;                          // unsigned range registers
    localparam int HINT_W  = 17;
    localparam int DELTA_W = 32;
    localparam int POS_W   = 34;                          // signed position
    localparam int PROD_W  = DELTA_W + RATE_W + 1;        // signed product
    localparam int SUM_W   = 42;                          // position + increment
    localparam int RNG_W   = 35;                          // signed start/end, span
    localparam int CFG_W   = 33;
    localparam int IDX_W   = 3;
    localparam int TDATA_W = 40;

    // Remainder unit
    localparam int DIV_STEPS = RNG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_RATE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOOP_ENABLE = 3'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_ENABLE = 3'd2;
    localparam logic [IDX_W-1:0] REG_FIRST_FRAME = 3'd3;
    localparam logic [IDX_W-1:0] REG_LAST_FRAME  = 3'd4;
    localparam logic [IDX_W-1:0] REG_HINT        = 3'd5;
    localparam logic [IDX_W-1:0] REG_RESTART     = 3'd6;

    // Item kinds
    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_SET_RUN = 1'b1;

    // Register reset values
    localparam logic [RATE_W-1:0]  RST_FRAME_RATE = 16'd7680;
    localparam logic [FRAME_W-1:0] RST_LAST_FRAME =
        FRAME_W'(MAX_FRAMES) << FRAC_BITS;
    localparam logic [HINT_W-1:0]  RST_HINT       = HINT_W'(MAX_FRAMES);

    localparam logic signed [RNG_W-1:0] ONE_FRAME = RNG_W'(1) << FRAC_BITS;

endpackage

// ----- hdl/animation_frame_loop_counter.sv -----
// Sequence: a set-running item goes from acceptance to the MUL state, then DONE loads the
// result; an advance item runs multiply, sum, range test, then (when it wraps) the 35-step
// remainder and finish, then the load, which waits until the output is free. One item at a
// time: the next is accepted the cycle after the result loads; the 35 single-bit steps of
// the shared shift/subtract remainder unit set the pace of an advance item.
// Reset (aresetn low, synchronous): position 0, not running, registers to defaults.
module animation_frame_loop_counter (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wen,
    input  logic [aflc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [aflc_pkg::CFG_W-1:0]       cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [aflc_pkg::TDATA_W-1:0]     s_tdata,  // [31:0] delta_seconds, [32] run_request
    input  logic                             s_tuser,  // [0] kind
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [aflc_pkg::TDATA_W-1:0]     m_tdata   // [33:0] frame_position, [34] is_running
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam int POS_W  = aflc_pkg::POS_W;
    localparam int RNG_W  = aflc_pkg::RNG_W;
    localparam int SUM_W  = aflc_pkg::SUM_W;
    localparam int PROD_W = aflc_pkg::PROD_W;

    // Configuration registers
    logic [aflc_pkg::RATE_W-1:0]  frame_rate_reg;
    logic                         loop_enable_reg;
    logic                         hold_enable_reg;
    logic [aflc_pkg::FRAME_W-1:0] first_frame_reg;
    logic [aflc_pkg::FRAME_W-1:0] last_frame_reg;
    logic [aflc_pkg::HINT_W-1:0]  hint_reg;
    logic                         restart_reg;

    // Control state
    logic [2:0]                   state_reg, state_next;
    logic signed [POS_W-1:0]      pos_reg, pos_next;
    logic                         run_reg, run_next;
    logic                         m_valid_reg, m_valid_next;
    logic [aflc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    // Payload registers
    logic                         kind_reg;
    logic signed [aflc_pkg::DELTA_W-1:0] delta_reg;
    logic                         req_reg;
    logic signed [PROD_W-1:0]     mul_reg, mul_next;
    logic signed [POS_W-1:0]      sum_reg, sum_next;
    logic signed [RNG_W-1:0]      end_reg, end_next;
    logic signed [RNG_W-1:0]      start_reg, start_next;
    logic signed [RNG_W-1:0]      base_reg, base_next;
    logic                         neg_reg, neg_next;
    logic [RNG_W-1:0]             span_reg, span_next;
    logic [RNG_W-1:0]             dvd_reg, dvd_next;
    logic [RNG_W:0]               rem_reg, rem_next;
    logic [POS_W-1:0]             m_pos_reg, m_pos_next;
    logic                         m_run_reg, m_run_next;

    // Datapath terms
    logic signed [PROD_W-1:0]     inc_full;
    logic signed [SUM_W-1:0]      sum_w;
    logic                         sum_ovf;
    logic signed [RNG_W-1:0]      hint_end;
    logic signed [RNG_W-1:0]      last_ext;
    logic signed [RNG_W-1:0]      end_w;
    logic signed [RNG_W-1:0]      first_ext;
    logic signed [RNG_W-1:0]      pos_ext;
    logic                         below, above, clamp;
    logic [RNG_W:0]               trial;
    logic signed [RNG_W:0]        fin_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(aflc_pkg::TDATA_W - POS_W - 1){1'b0}}, m_run_reg, m_pos_reg};

    // Increment, sum and overflow test for saturation
    assign inc_full = mul_reg >>> aflc_pkg::PROD_SHIFT;
    assign sum_w    = SUM_W'(pos_reg) + inc_full[SUM_W-1:0];
    assign sum_ovf  = (sum_w[SUM_W-1:POS_W-1] != {(SUM_W-POS_W+1){sum_w[POS_W-1]}});

    // Play range
    assign first_ext = $signed({{(RNG_W-aflc_pkg::FRAME_W){1'b0}}, first_frame_reg});
    assign last_ext  = $signed({{(RNG_W-aflc_pkg::FRAME_W){1'b0}}, last_frame_reg});
    assign hint_end  = $signed(RNG_W'({hint_reg, {aflc_pkg::FRAC_BITS{1'b0}}}))
                       - (loop_enable_reg ? RNG_W'(0) : aflc_pkg::ONE_FRAME);
    assign end_w     = (last_ext < hint_end) ? last_ext : hint_end;

    // Range test
    assign pos_ext = RNG_W'(pos_reg);
    assign below   = (pos_ext < start_reg);
    assign above   = (pos_ext > end_reg);
    assign clamp   = (!loop_enable_reg && (below || above)) || (start_reg == end_reg);

    // One restoring remainder step
    assign trial = {rem_reg[RNG_W-1:0], dvd_reg[RNG_W-1]};

    // Wrapped result
    assign fin_w = neg_reg ? ((RNG_W+1)'(base_reg) - $signed(rem_reg))
                           : ((RNG_W+1)'(base_reg) + $signed(rem_reg));

    // Sequencer and datapath next values
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        run_next     = run_reg;
        m_valid_next = m_valid_reg;
        cnt_next     = cnt_reg;
        mul_next     = mul_reg;
        sum_next     = sum_reg;
        end_next     = end_reg;
        start_next   = start_reg;
        base_next    = base_reg;
        neg_next     = neg_reg;
        span_next    = span_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        m_pos_next   = m_pos_reg;
        m_run_next   = m_run_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (kind_reg == aflc_pkg::KIND_SET_RUN) begin
                    if (req_reg != run_reg) begin
                        run_next = req_reg;
                        if (req_reg && restart_reg) begin
                            pos_next = POS_W'(first_frame_reg);
                        end
                    end
                    state_next = ST_DONE;
                end else begin
                    mul_next   = PROD_W'(delta_reg)
                                 * $signed({1'b0, frame_rate_reg});
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_ovf) begin
                    sum_next = sum_w[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                              : {1'b0, {(POS_W-1){1'b1}}};
                end else begin
                    sum_next = sum_w[POS_W-1:0];
                end
                end_next   = end_w;
                start_next = (first_ext < end_w) ? first_ext : end_w;
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                // pos_reg now holds the saturated sum
                span_next = RNG_W'(end_reg - start_reg);
                rem_next  = '0;
                cnt_next  = aflc_pkg::CNT_W'(aflc_pkg::DIV_STEPS - 1);
                if (clamp) begin
                    if (below) begin
                        pos_next = start_reg[POS_W-1:0];
                    end else if (above) begin
                        pos_next = end_reg[POS_W-1:0];
                    end
                    if (!hold_enable_reg) begin
                        run_next = 1'b0;
                    end
                    state_next = ST_DONE;
                end else if (below) begin
                    base_next  = end_reg;
                    neg_next   = 1'b1;
                    dvd_next   = RNG_W'(end_reg - pos_ext);
                    state_next = ST_DIV;
                end else if (above) begin
                    base_next  = start_reg;
                    neg_next   = 1'b0;
                    dvd_next   = RNG_W'(pos_ext - start_reg);
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                rem_next = (trial >= {1'b0, span_reg}) ? (trial - {1'b0, span_reg}) : trial;
                dvd_next = {dvd_reg[RNG_W-2:0], 1'b0};
                cnt_next = cnt_reg - aflc_pkg::CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                pos_next   = fin_w[POS_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_pos_next   = pos_reg;
                    m_run_next   = run_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // saturated sum becomes the working position
        if (state_reg == ST_SUM) begin
            pos_next = (sum_ovf) ? sum_next : sum_w[POS_W-1:0];
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            run_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            cnt_reg         <= '0;
            frame_rate_reg  <= aflc_pkg::RST_FRAME_RATE;
            loop_enable_reg <= 1'b1;
            hold_enable_reg <= 1'b0;
            first_frame_reg <= '0;
            last_frame_reg  <= aflc_pkg::RST_LAST_FRAME;
            hint_reg        <= aflc_pkg::RST_HINT;
            restart_reg     <= 1'b1;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            if (cfg_wen) begin
                unique case (cfg_index)
                    aflc_pkg::REG_FRAME_RATE:  frame_rate_reg  <= cfg_wdata[aflc_pkg::RATE_W-1:0];
                    aflc_pkg::REG_LOOP_ENABLE: loop_enable_reg <= cfg_wdata[0];
                    aflc_pkg::REG_HOLD_ENABLE: hold_enable_reg <= cfg_wdata[0];
                    aflc_pkg::REG_FIRST_FRAME: first_frame_reg <= cfg_wdata;
                    aflc_pkg::REG_LAST_FRAME:  last_frame_reg  <= cfg_wdata;
                    aflc_pkg::REG_HINT:        hint_reg        <= cfg_wdata[aflc_pkg::HINT_W-1:0];
                    aflc_pkg::REG_RESTART:     restart_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            delta_reg <= $signed(s_tdata[aflc_pkg::DELTA_W-1:0]);
            req_reg   <= s_tdata[aflc_pkg::DELTA_W];
        end
        mul_reg   <= mul_next;
        sum_reg   <= sum_next;
        end_reg   <= end_next;
        start_reg <= start_next;
        base_reg  <= base_next;
        neg_reg   <= neg_next;
        span_reg  <= span_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        m_pos_reg <= m_pos_next;
        m_run_reg <= m_run_next;
    end

    // Remainder stays below the span throughout the division
    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, span_reg}))
        else $error("remainder not below span");

    // Only one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    // A new result appears only when the sequencer finishes an item
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result without finished item");

endmodule
